FILE: sv/mceb_pkg.sv
// Shared types and constants of the monochrome color expansion blit.
package mceb_pkg;

  localparam int MCEB_MAX_DIM   = 4096;
  localparam int MCEB_ADDR_BITS = 24;
  localparam int MCEB_Q_DEPTH   = 4;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 24;
  localparam int OUT_ADDR_W = 24;
  localparam int PITCH_W    = 10;
  localparam int NPIX_W     = 4;

  localparam logic [PITCH_W-1:0] BIR_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLOR_PAIR   = 4'd0,
    REG_OPAQUE_MODE  = 4'd1,
    REG_BIT_OFFSET   = 4'd2,
    REG_PIXEL_WIDTH  = 4'd3,
    REG_PIXEL_HEIGHT = 4'd4,
    REG_SRC_PITCH    = 4'd5,
    REG_DST_PITCH    = 4'd6,
    REG_DEST_START   = 4'd7
  } reg_idx_t;

  typedef struct packed {
    logic [15:0]        color_pair;
    logic               opaque_mode;
    logic [2:0]         bit_offset;
    logic [12:0]        pixel_width;
    logic [12:0]        pixel_height;
    logic [PITCH_W-1:0] src_pitch;
    logic [15:0]        dst_pitch;
    logic [23:0]        dest_start;
  } cfg_t;

  // Work for the back end: one source byte and the run of pixels it yields.
  typedef struct packed {
    logic [7:0]        src_byte;
    logic [2:0]        pos;
    logic [NPIX_W-1:0] npix;
    logic              done;
  } desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

FILE: sv/mceb_ifs.sv
// Valid/ready channel interfaces for source bytes and pixel results.
interface mceb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] src_byte;

  modport source (output valid, output src_byte, input ready);
  modport sink   (input valid, input src_byte, output ready);
endinterface

interface mceb_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] dest_address;
  logic [7:0]  pixel_color;
  logic        write_enable;
  logic        last_of_byte;
  logic        blit_done;

  modport source (output valid, output dest_address, output pixel_color,
                  output write_enable, output last_of_byte, output blit_done,
                  input ready);
  modport sink   (input valid, input dest_address, input pixel_color,
                  input write_enable, input last_of_byte, input blit_done,
                  output ready);
endinterface

FILE: sv/mceb_fifo.sv
// Short queue of byte descriptors between the front and back ends.
module mceb_fifo
  import mceb_pkg::*;
#(
  parameter int WIDTH = 16,
  parameter int DEPTH = MCEB_Q_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output q_stat_t          stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign stat.full  = (cnt_r == CNT_FULL);
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: sv/mceb_front.sv
// Front end: takes source bytes, tracks the row walk and queues pixel runs.
module mceb_front
  import mceb_pkg::*;
#(
  parameter int MAX_DIM   = MCEB_MAX_DIM,
  parameter int ADDR_BITS = MCEB_ADDR_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  mceb_in_if.sink              in_ch,
  input  cfg_t                 cfg,
  input  logic                 restart,
  input  q_stat_t              q_stat,
  output logic                 push,
  output desc_t                push_desc,
  output logic [ADDR_BITS-1:0] push_addr
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);

  logic [DIM_W-1:0]     col_r, col_nxt;
  logic [DIM_W-1:0]     row_r, row_nxt;
  logic [PITCH_W-1:0]   bir_r, bir_nxt;
  logic [ADDR_BITS-1:0] row_addr_r, row_addr_nxt;
  logic [ADDR_BITS-1:0] pix_addr_r, pix_addr_nxt;

  logic [31:0]          w32, h32;
  logic [DIM_W-1:0]     width, height;
  logic [PITCH_W-1:0]   pitch;
  logic                 at_start;
  logic [ADDR_BITS-1:0] start_addr, row_base, pix_base, row_step;
  logic [2:0]           pos;
  logic [NPIX_W-1:0]    avail, npix;
  logic [DIM_W-1:0]     rem, col_new;
  logic [PITCH_W-1:0]   bir_new;
  logic                 last_row, row_end, accept;

  always_comb begin
    w32 = 32'(cfg.pixel_width);
    if (w32 == 32'd0) begin
      w32 = 32'd1;
    end else if (w32 > 32'(MAX_DIM)) begin
      w32 = 32'(MAX_DIM);
    end
    h32 = 32'(cfg.pixel_height);
    if (h32 == 32'd0) begin
      h32 = 32'd1;
    end else if (h32 > 32'(MAX_DIM)) begin
      h32 = 32'(MAX_DIM);
    end
  end

  assign width  = DIM_W'(w32);
  assign height = DIM_W'(h32);
  assign pitch  = (cfg.src_pitch == '0) ? PITCH_W'(1) : cfg.src_pitch;

  // Row zero with no byte taken only occurs at the start of a blit.
  assign at_start   = (row_r == '0) && (bir_r == '0);
  assign start_addr = ADDR_BITS'(32'(cfg.dest_start));
  assign row_base   = at_start ? start_addr : row_addr_r;
  assign pix_base   = at_start ? start_addr : pix_addr_r;
  assign row_step   = ADDR_BITS'(32'(cfg.dst_pitch));

  assign pos   = (bir_r == '0) ? cfg.bit_offset : 3'd0;
  assign avail = NPIX_W'(8) - {1'b0, pos};
  assign rem   = width - col_r;
  assign npix  = (32'(rem) < 32'(avail)) ? NPIX_W'(rem) : avail;

  assign col_new  = col_r + DIM_W'(npix);
  // Saturation keeps the pitch compare right on rows longer than the pitch.
  assign bir_new  = (bir_r == BIR_MAX) ? bir_r : bir_r + 1'b1;
  assign last_row = ((row_r + 1'b1) == height);
  assign row_end  = (col_new >= width) && (bir_new >= pitch);

  assign in_ch.ready = !q_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;

  assign push               = accept && (npix != '0);
  assign push_desc.src_byte = in_ch.src_byte;
  assign push_desc.pos      = pos;
  assign push_desc.npix     = npix;
  assign push_desc.done     = (col_new == width) && last_row;
  assign push_addr          = pix_base;

  always_comb begin
    col_nxt      = col_r;
    row_nxt      = row_r;
    bir_nxt      = bir_r;
    row_addr_nxt = row_addr_r;
    pix_addr_nxt = pix_addr_r;
    if (accept) begin
      row_addr_nxt = row_base;
      pix_addr_nxt = pix_base + ADDR_BITS'(npix);
      col_nxt      = col_new;
      bir_nxt      = bir_new;
      if (row_end) begin
        col_nxt = '0;
        bir_nxt = '0;
        if (last_row) begin
          row_nxt = '0;
        end else begin
          row_nxt      = row_r + 1'b1;
          row_addr_nxt = row_base + row_step;
          pix_addr_nxt = row_base + row_step;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      col_r <= '0;
      row_r <= '0;
      bir_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      bir_r <= bir_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_addr_r <= row_addr_nxt;
    pix_addr_r <= pix_addr_nxt;
  end

endmodule

FILE: sv/mceb_back.sv
// Back end: walks the queued pixel runs and drives one pixel beat per cycle while out_ch is ready.
module mceb_back
  import mceb_pkg::*;
#(
  parameter int ADDR_BITS = MCEB_ADDR_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cfg_t                 cfg,
  input  q_stat_t              q_stat,
  input  desc_t                head,
  input  logic [ADDR_BITS-1:0] head_addr,
  output logic                 pop,
  mceb_out_if.source           out_ch
);

  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_ADDR_W-1:0] dest_address_r;
  logic [7:0]            pixel_color_r;
  logic                  write_enable_r;
  logic                  last_of_byte_r;
  logic                  blit_done_r;
  logic [2:0]            k_r, k_nxt;

  logic                  load, bit_val, last;
  logic [2:0]            pos;
  logic [ADDR_BITS-1:0]  addr;
  logic [31:0]           addr32;
  logic [7:0]            fg, bg, color;
  logic                  we;

  assign load = !q_stat.empty && (!out_valid_r || out_ch.ready);
  assign pos  = head.pos + k_r;
  // Bit 7 - pos of the byte, msb first.
  assign bit_val = head.src_byte[~pos];
  assign last    = (({1'b0, k_r} + 1'b1) == head.npix);
  assign addr    = head_addr + ADDR_BITS'(k_r);
  assign addr32  = 32'(addr);
  assign pop     = load && last;

  assign fg = cfg.color_pair[7:0];
  assign bg = cfg.color_pair[15:8];

  always_comb begin
    if (cfg.opaque_mode) begin
      we    = 1'b1;
      color = bit_val ? fg : bg;
    end else begin
      we    = bit_val;
      color = bit_val ? fg : 8'd0;
    end
  end

  always_comb begin
    k_nxt = k_r;
    if (load) begin
      k_nxt = last ? 3'd0 : k_r + 1'b1;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      k_r         <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      k_r         <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dest_address_r <= addr32[OUT_ADDR_W-1:0];
      pixel_color_r  <= color;
      write_enable_r <= we;
      last_of_byte_r <= last;
      blit_done_r    <= last && head.done;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.dest_address = dest_address_r;
  assign out_ch.pixel_color  = pixel_color_r;
  assign out_ch.write_enable = write_enable_r;
  assign out_ch.last_of_byte = last_of_byte_r;
  assign out_ch.blit_done    = blit_done_r;

endmodule

FILE: sv/mono_color_expansion_blit.sv
// Top level of the monochrome color expansion blit: registers, front, queue, back.
// Source bytes arrive as beats on in_ch and expand into one pixel beat per used bit
// on out_ch. The front end takes one source byte per cycle while its four-entry
// queue has room; the back end drives one pixel per cycle while out_ch is ready,
// so a byte that yields k pixels (up to eight) gives k pixel beats and a padding
// byte gives none. Sustained throughput is set by the back end's single pixel
// per cycle. Registers are written via cfg_we / cfg_index / cfg_wdata; any valid
// write restarts the blit at dest_start.
module mono_color_expansion_blit
  import mceb_pkg::*;
#(
  parameter int MAX_DIM   = MCEB_MAX_DIM,
  parameter int ADDR_BITS = MCEB_ADDR_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  mceb_in_if.sink               in_ch,
  mceb_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int Q_W = ADDR_BITS + $bits(desc_t);

  cfg_t                 cfg_r, cfg_nxt;
  logic                 restart;
  q_stat_t              q_stat;
  logic                 push, pop;
  desc_t                push_desc, head;
  logic [ADDR_BITS-1:0] push_addr, head_addr;
  logic [Q_W-1:0]       q_rd_data;

  always_comb begin
    cfg_nxt = cfg_r;
    restart = 1'b0;
    if (cfg_we) begin
      restart = 1'b1;
      case (cfg_index)
        REG_COLOR_PAIR:   cfg_nxt.color_pair   = cfg_wdata[15:0];
        REG_OPAQUE_MODE:  cfg_nxt.opaque_mode  = cfg_wdata[0];
        REG_BIT_OFFSET:   cfg_nxt.bit_offset   = cfg_wdata[2:0];
        REG_PIXEL_WIDTH:  cfg_nxt.pixel_width  = cfg_wdata[12:0];
        REG_PIXEL_HEIGHT: cfg_nxt.pixel_height = cfg_wdata[12:0];
        REG_SRC_PITCH:    cfg_nxt.src_pitch    = cfg_wdata[PITCH_W-1:0];
        REG_DST_PITCH:    cfg_nxt.dst_pitch    = cfg_wdata[15:0];
        REG_DEST_START:   cfg_nxt.dest_start   = cfg_wdata[23:0];
        default:          restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.color_pair   <= '0;
      cfg_r.opaque_mode  <= 1'b0;
      cfg_r.bit_offset   <= '0;
      cfg_r.pixel_width  <= 13'd1;
      cfg_r.pixel_height <= 13'd1;
      cfg_r.src_pitch    <= PITCH_W'(1);
      cfg_r.dst_pitch    <= 16'd1;
      cfg_r.dest_start   <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  mceb_front #(
    .MAX_DIM   (MAX_DIM),
    .ADDR_BITS (ADDR_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg       (cfg_r),
    .restart   (restart),
    .q_stat    (q_stat),
    .push      (push),
    .push_desc (push_desc),
    .push_addr (push_addr)
  );

  mceb_fifo #(
    .WIDTH (Q_W),
    .DEPTH (MCEB_Q_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_addr, push_desc}),
    .pop       (pop),
    .pop_data  (q_rd_data),
    .stat      (q_stat)
  );

  assign head_addr = q_rd_data[Q_W-1 -: ADDR_BITS];
  assign head      = q_rd_data[$bits(desc_t)-1:0];

  mceb_back #(
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_stat    (q_stat),
    .head      (head),
    .head_addr (head_addr),
    .pop       (pop),
    .out_ch    (out_ch)
  );

  // A pixel that is not the last of its byte is followed at once by the next one.
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && !out_ch.last_of_byte) |=> out_ch.valid)
    else $error("pixel run broken before last_of_byte");

  // With nothing queued, an idle output stage stays idle.
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    (q_stat.empty && !out_ch.valid) |=> !out_ch.valid)
    else $error("pixel beat without a queued byte");

  // The final pixel of a bitmap always closes its byte.
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.blit_done) |-> out_ch.last_of_byte)
    else $error("blit_done on a pixel that is not last of its byte");

  // The queue never reports full and empty together.
  a_q_stat: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue status inconsistent");

endmodule

FILE: tb/mceb_pixel_checker.sv
// Scoreboard for the color expansion blit: predicts pixel beats from source beats and checks them.
`timescale 1ns / 1ps
module mceb_pixel_checker
  import mceb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  mceb_in_if                    src_mon,
  mceb_out_if                   pix_mon,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending_pixels
);

  typedef struct packed {
    logic [OUT_ADDR_W-1:0] dest_address;
    logic [7:0]            pixel_color;
    logic                  write_enable;
    logic                  last_of_byte;
    logic                  blit_done;
  } pixel_t;

  cfg_t                  regs;
  int                    col_cnt;
  int                    row_cnt;
  int                    bytes_in_row;
  logic [OUT_ADDR_W-1:0] row_addr;
  logic [OUT_ADDR_W-1:0] pix_addr;
  pixel_t                expected_pixels[$];
  int                    mismatch_count = 0;

  function automatic int clamp_dim(input logic [12:0] v);
    if (v == 13'd0) return 1;
    if (v > MCEB_MAX_DIM) return MCEB_MAX_DIM;
    return int'(v);
  endfunction

  function automatic int field_differs(input string name, input logic [23:0] want,
                                       input logic [23:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  task automatic restart_blit();
    col_cnt = 0;
    row_cnt = 0;
    bytes_in_row = 0;
    row_addr = regs.dest_start;
    pix_addr = regs.dest_start;
  endtask

  task automatic apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    bit known;
    known = 1'b1;
    case (idx)
      REG_COLOR_PAIR:   regs.color_pair   = d[15:0];
      REG_OPAQUE_MODE:  regs.opaque_mode  = d[0];
      REG_BIT_OFFSET:   regs.bit_offset   = d[2:0];
      REG_PIXEL_WIDTH:  regs.pixel_width  = d[12:0];
      REG_PIXEL_HEIGHT: regs.pixel_height = d[12:0];
      REG_SRC_PITCH:    regs.src_pitch    = d[PITCH_W-1:0];
      REG_DST_PITCH:    regs.dst_pitch    = d[15:0];
      REG_DEST_START:   regs.dest_start   = d[23:0];
      default:          known = 1'b0;
    endcase
    // Only a write to an existing register restarts the blit.
    if (known) restart_blit();
  endtask

  task automatic expand_source_byte(input logic [7:0] sb);
    int     width;
    int     height;
    int     pitch;
    int     pos;
    int     n;
    int     i;
    logic   bitv;
    pixel_t run [8];
    width  = clamp_dim(regs.pixel_width);
    height = clamp_dim(regs.pixel_height);
    pitch  = (regs.src_pitch == '0) ? 1 : int'(regs.src_pitch);
    pos    = (bytes_in_row == 0) ? int'(regs.bit_offset) : 0;
    n      = 0;
    while (pos < 8 && col_cnt < width) begin
      bitv = sb[7 - pos];
      run[n].dest_address = pix_addr;
      run[n].write_enable = regs.opaque_mode | bitv;
      if (bitv) run[n].pixel_color = regs.color_pair[7:0];
      else if (regs.opaque_mode) run[n].pixel_color = regs.color_pair[15:8];
      else run[n].pixel_color = 8'h00;
      run[n].last_of_byte = 1'b0;
      col_cnt++;
      run[n].blit_done = (col_cnt >= width) && (row_cnt + 1 >= height);
      pix_addr = pix_addr + 1'b1;
      n++;
      pos++;
    end
    for (i = 0; i < n; i++) begin
      if (i == n - 1) run[i].last_of_byte = 1'b1;
      expected_pixels.push_back(run[i]);
    end
    // A row ends once its pixels are done and its pitch worth of bytes is in.
    bytes_in_row++;
    if (col_cnt >= width && bytes_in_row >= pitch) begin
      row_cnt++;
      if (row_cnt >= height) begin
        restart_blit();
      end else begin
        col_cnt = 0;
        bytes_in_row = 0;
        row_addr = row_addr + regs.dst_pitch;
        pix_addr = row_addr;
      end
    end
  endtask

  always @(posedge clk) begin
    pixel_t want;
    if (!rst_n) begin
      regs = '0;
      regs.pixel_width  = 13'd1;
      regs.pixel_height = 13'd1;
      regs.src_pitch    = 10'd1;
      regs.dst_pitch    = 16'd1;
      restart_blit();
      expected_pixels.delete();
    end else begin
      // The output beat is checked before this edge's source beat is expanded.
      if (pix_mon.valid && pix_mon.ready) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected pixel beat at dest_address 0x%0h", pix_mon.dest_address);
          mismatch_count++;
        end else begin
          want = expected_pixels.pop_front();
          mismatch_count += field_differs("dest_address", want.dest_address,
                                          pix_mon.dest_address);
          mismatch_count += field_differs("pixel_color", want.pixel_color,
                                          pix_mon.pixel_color);
          mismatch_count += field_differs("write_enable", want.write_enable,
                                          pix_mon.write_enable);
          mismatch_count += field_differs("last_of_byte", want.last_of_byte,
                                          pix_mon.last_of_byte);
          mismatch_count += field_differs("blit_done", want.blit_done, pix_mon.blit_done);
        end
      end
      if (cfg_we) apply_write(cfg_index, cfg_wdata);
      if (src_mon.valid && src_mon.ready) expand_source_byte(src_mon.src_byte);
    end
    fail_count     <= mismatch_count;
    pending_pixels <= expected_pixels.size();
  end

endmodule

FILE: tb/tb_mono_color_expansion_blit.sv
// Testbench top for the color expansion blit: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_mono_color_expansion_blit
  import mceb_pkg::*;
();

  localparam int RAND_ITEMS       = 230;
  localparam int DRAIN_CYCLES     = 32;
  localparam int TIMEOUT_NS       = 2_000_000;
  localparam int FIRST_UNUSED_IDX = 8;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    fail_count;
  int                    pending_pixels;
  int                    send_idle_pct;
  int                    recv_idle_pct;
  int                    sent;
  int                    s_off;
  int                    s_w;
  int                    s_h;
  int                    s_pitch;

  mceb_in_if  src_ch ();
  mceb_out_if pix_ch ();

  mono_color_expansion_blit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (src_ch),
    .out_ch    (pix_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  mceb_pixel_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .src_mon        (src_ch),
    .pix_mon        (pix_ch),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .fail_count     (fail_count),
    .pending_pixels (pending_pixels)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    pix_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      pix_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Register writes carry random fill above the field to show it is ignored.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] field,
                           input int w);
    logic [CFG_DATA_W-1:0] fill;
    logic [CFG_DATA_W-1:0] keep;
    fill = CFG_DATA_W'($urandom);
    keep = (w >= CFG_DATA_W) ? '1 : ((24'h1 << w) - 24'h1);
    cfg_index <= idx;
    cfg_wdata <= (field & keep) | (fill & ~keep);
    cfg_we    <= 1'b1;
    @(posedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b);
    cfg_we <= 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      src_ch.valid <= 1'b0;
      @(posedge clk);
    end
    src_ch.valid    <= 1'b1;
    src_ch.src_byte <= b;
    do @(posedge clk); while (!src_ch.ready);
  endtask

  task automatic send_random(input int n);
    int k;
    for (k = 0; k < n; k++) begin
      send_byte($urandom_range(255));
      sent++;
    end
  endtask

  // The extra cycles give a stray pixel beat time to show up before the next writes.
  task automatic wait_drain();
    cfg_we       <= 1'b0;
    src_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_pixels != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic int blit_bytes();
    int w;
    int h;
    int p;
    int need;
    w = (s_w == 0) ? 1 : s_w;
    h = (s_h == 0) ? 1 : s_h;
    p = (s_pitch == 0) ? 1 : s_pitch;
    need = (s_off + w + 7) / 8;
    return h * ((need > p) ? need : p);
  endfunction

  task automatic randomize_setup();
    int need;
    s_off = $urandom_range(7);
    s_w   = ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 40);
    s_h   = ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 4);
    need  = (s_off + ((s_w == 0) ? 1 : s_w) + 7) / 8;
    case ($urandom_range(3))
      0:       s_pitch = 0;
      1:       s_pitch = need;
      2:       s_pitch = need + $urandom_range(1, 3);
      default: s_pitch = $urandom_range(1, need);
    endcase
    write_reg(REG_COLOR_PAIR, $urandom, 16);
    write_reg(REG_OPAQUE_MODE, $urandom, 1);
    write_reg(REG_BIT_OFFSET, s_off, 3);
    write_reg(REG_PIXEL_WIDTH, s_w, 13);
    write_reg(REG_PIXEL_HEIGHT, s_h, 13);
    write_reg(REG_SRC_PITCH, s_pitch, 10);
    write_reg(REG_DST_PITCH, ($urandom_range(7) == 0) ? 16'hFFFF : $urandom, 16);
    write_reg(REG_DEST_START,
              ($urandom_range(3) == 0) ? (24'hFFFFC0 | $urandom_range(63)) : $urandom, 24);
  endtask

  initial begin
    int total;
    int split;
    int reps;
    int r;
    src_ch.valid    = 1'b0;
    src_ch.src_byte = 8'h00;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_wdata       = '0;
    rst_n           = 1'b0;
    send_idle_pct   = 23;
    recv_idle_pct   = 49;
    sent            = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: one transparent pixel per blit.
    send_byte(8'h80);
    send_byte(8'h7F);
    wait_drain();

    // Opaque two-row blit whose addresses wrap at the top of the space.
    write_reg(REG_COLOR_PAIR, 16'hA55A, 16);
    write_reg(REG_OPAQUE_MODE, 1, 1);
    write_reg(REG_BIT_OFFSET, 0, 3);
    write_reg(REG_PIXEL_WIDTH, 8, 13);
    write_reg(REG_PIXEL_HEIGHT, 2, 13);
    write_reg(REG_SRC_PITCH, 1, 10);
    write_reg(REG_DST_PITCH, 16'hFFFF, 16);
    write_reg(REG_DEST_START, 24'hFFFFFF, 24);
    send_byte(8'hFF);
    send_byte(8'h00);
    wait_drain();

    // Transparent, last bit offset, a row spanning two bytes plus one padding byte.
    write_reg(REG_OPAQUE_MODE, 0, 1);
    write_reg(REG_BIT_OFFSET, 7, 3);
    write_reg(REG_PIXEL_WIDTH, 3, 13);
    write_reg(REG_SRC_PITCH, 3, 10);
    write_reg(REG_DST_PITCH, 0, 16);
    write_reg(REG_DEST_START, 24'h000100, 24);
    send_byte(8'h01);
    send_byte(8'h80);
    send_byte(8'hAA);
    send_byte(8'h01);
    send_byte(8'hC0);
    send_byte(8'h55);
    wait_drain();

    // Zero pitch acts as one, which is also too small for a 20-pixel row.
    write_reg(REG_COLOR_PAIR, 16'h00FF, 16);
    write_reg(REG_OPAQUE_MODE, 1, 1);
    write_reg(REG_BIT_OFFSET, 4, 3);
    write_reg(REG_PIXEL_WIDTH, 20, 13);
    write_reg(REG_PIXEL_HEIGHT, 1, 13);
    write_reg(REG_SRC_PITCH, 0, 10);
    send_byte(8'hC3);
    send_byte(8'h3C);
    send_byte(8'h5A);
    wait_drain();

    // Zero dimensions clamp to a single pixel.
    write_reg(REG_PIXEL_WIDTH, 0, 13);
    write_reg(REG_PIXEL_HEIGHT, 0, 13);
    send_byte(8'h08);
    wait_drain();

    // Oversized dimensions clamp to the maximum; unused indexes must not restart.
    write_reg(REG_PIXEL_WIDTH, 13'h1FFF, 13);
    write_reg(REG_PIXEL_HEIGHT, 13'h1FFF, 13);
    write_reg(REG_SRC_PITCH, 10'h3FF, 10);
    write_reg(REG_BIT_OFFSET, 0, 3);
    write_reg(REG_DST_PITCH, 16'h1234, 16);
    write_reg(REG_DEST_START, 24'hABCDEF, 24);
    send_byte(8'hF0);
    send_byte(8'h0F);
    send_byte(8'h96);
    wait_drain();
    write_reg(FIRST_UNUSED_IDX + 7, 24'hFFFFFF, 24);
    write_reg(FIRST_UNUSED_IDX, 24'h000000, 24);
    send_byte(8'h69);
    send_byte(8'hFF);
    wait_drain();
    write_reg(REG_COLOR_PAIR, 16'h3CC3, 16);
    send_byte(8'hA5);
    wait_drain();

    while (sent < RAND_ITEMS) begin
      if (sent >= 2 * RAND_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (sent >= RAND_ITEMS / 3) begin
        send_idle_pct = 49;
        recv_idle_pct = 23;
      end
      randomize_setup();
      total = blit_bytes();
      reps  = $urandom_range(1, 2);
      for (r = 0; r < reps; r++) begin
        split = (total > 1 && $urandom_range(5) == 0) ? $urandom_range(1, total - 1) : 0;
        if (split != 0) begin
          send_random(split);
          wait_drain();
          write_reg(FIRST_UNUSED_IDX + $urandom_range(7), $urandom, 24);
          send_random(total - split);
        end else begin
          send_random(total);
        end
      end
      // An unfinished blit left behind is cut short by the next setup's writes.
      if (total > 1 && $urandom_range(9) == 0) send_random($urandom_range(1, total - 1));
      wait_drain();
    end

    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
